// ===== hdl/mecr_pkg.sv =====
// Shared types, sizes and coefficient tables of the min-eigenvalue corner scorer.
// Used by the controller, the datapath, the root unit and the top level.
package mecr_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int ColW      = 10;              // column field width
	localparam int RowW      = 10;              // row field width
	localparam int DimW      = 11;              // size register width
	localparam int PixLines  = 4;
	localparam int ProdLines = 8;
	localparam int PixLb     = $clog2(PixLines);
	localparam int ProdLb    = $clog2(ProdLines);
	localparam int PixAw     = PixLb + ColW;
	localparam int ProdAw    = ProdLb + ColW;
	localparam int PixDepth  = PixLines * MaxWidth;
	localparam int ProdDepth = ProdLines * MaxWidth;
	localparam int PixW      = 8;
	localparam int XxW       = 21;
	localparam int XyW       = 22;
	localparam int ProdW     = 2 * XxW + XyW;   // yy, xy, xx
	localparam int RespW     = 21;
	localparam int SqW       = 44;
	localparam int RootW     = 22;
	localparam int TapW      = 5;
	localparam int ProdTaps  = 9;
	localparam int ScoreTaps = 25;
	localparam int OutDataW  = 48;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic REQ_PIXEL  = 1'b0;
	localparam logic REQ_FLUSH  = 1'b1;

	localparam logic [DimW-1:0] WIDTH_RST  = 11'd640;
	localparam logic [DimW-1:0] HEIGHT_RST = 11'd480;

	// Sobel taps in raster order of the 3x3 window
	localparam logic signed [2:0] SOB_X [ProdTaps] =
		'{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2, -3'sd1, 3'sd0, 3'sd1};
	localparam logic signed [2:0] SOB_Y [ProdTaps] =
		'{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd1};
	localparam logic [1:0] TAP_DI [ProdTaps] =
		'{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
	localparam logic [1:0] TAP_DJ [ProdTaps] =
		'{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

	// 5x5 binomial window, offsets stored plus two
	localparam logic [2:0] SC_DY [ScoreTaps] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
	localparam logic [2:0] SC_DX [ScoreTaps] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
	localparam logic [5:0] SC_WT [ScoreTaps] = '{
		6'd1, 6'd4, 6'd6, 6'd4, 6'd1,
		6'd4, 6'd16, 6'd24, 6'd16, 6'd4,
		6'd6, 6'd24, 6'd36, 6'd24, 6'd6,
		6'd4, 6'd16, 6'd24, 6'd16, 6'd4,
		6'd1, 6'd4, 6'd6, 6'd4, 6'd1};

	typedef enum logic [3:0] {
		ST_IDLE, ST_PCHK, ST_PRD, ST_PMUL, ST_PWR, ST_OCHK, ST_SRD,
		ST_RND, ST_SQM, ST_SQS, ST_ROOT, ST_SUM, ST_EMIT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic tap_clr;
		logic prd_step;
		logic pmul;
		logic pwr;
		logic srd_step;
		logic rnd;
		logic sqm;
		logic sqs;
		logic sum;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic prod_go;
		logic out_go;
		logic prd_done;
		logic srd_done;
		logic root_done;
		logic out_free;
	} stat_t;

endpackage

// ===== hdl/min_eigen_corner_response.sv =====
// Top level of the min-eigenvalue (Shi-Tomasi) corner scorer.
// Depends on mecr_pkg, mecr_ctrl and mecr_dp.
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tdata: pixel; tuser: req_type
//  m_*      out        m_tvalid/m_tready  tdata: response, col, row; tlast: last_of_frame
//  cfg_*    in         cfg_we             cfg_addr: register index; cfg_data: value
//
// One request at a time. A request that yields a score makes 25 product-store reads
// and 22 root steps, and each structure product made reads nine pixel-store taps;
// the final pixel of a frame makes up to W+2 products at once.
// Asynchronous active-low reset; the line stores are not cleared.
// s_tready is high only between requests; a stalled m_tready holds the last step.
module min_eigen_corner_response (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel
	input  logic                          s_tuser,   // [0] req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mecr_pkg::OutDataW-1:0] m_tdata,   // [20:0] response, [30:21] col, [40:31] row
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [mecr_pkg::DimW-1:0]     cfg_data
);
	import mecr_pkg::*;

	cmd_t  cmd;
	stat_t st;

	mecr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.st       (st),
		.cmd      (cmd)
	);

	mecr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	assign s_tready = cmd.in_ready;
endmodule

// ===== hdl/mecr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mecr_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/mecr_isqrt.sv =====
// Integer square root, one result bit per cycle (restoring method).
// Depends on mecr_pkg for widths.
module mecr_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mecr_pkg::SqW-1:0]   value,
	output logic                       done,
	output logic [mecr_pkg::RootW-1:0] root
);
	import mecr_pkg::*;

	logic [SqW-1:0] v_q, r_q, bit_q, trial;
	logic           busy_q;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else if (start) busy_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= SqW'(1) << (SqW - 2);
		end else if (busy_q && bit_q != '0) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = busy_q && (bit_q == '0);
	assign root = r_q[RootW-1:0];
endmodule

// ===== hdl/mecr_ctrl.sv =====
// Sequencing state machine: steps one request through product and score passes.
// Depends on mecr_pkg for state, command and status types.
module mecr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  mecr_pkg::stat_t st,
	output mecr_pkg::cmd_t  cmd
);
	import mecr_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_PCHK;
			ST_PCHK: state_nx = st.prod_go ? ST_PRD : ST_OCHK;
			ST_PRD:  if (st.prd_done) state_nx = ST_PMUL;
			ST_PMUL: state_nx = ST_PWR;
			ST_PWR:  state_nx = ST_PCHK;
			ST_OCHK: state_nx = st.out_go ? ST_SRD : ST_IDLE;
			ST_SRD:  if (st.srd_done) state_nx = ST_RND;
			ST_RND:  state_nx = ST_SQM;
			ST_SQM:  state_nx = ST_SQS;
			ST_SQS:  state_nx = ST_ROOT;
			ST_ROOT: if (st.root_done) state_nx = ST_SUM;
			ST_SUM:  state_nx = ST_EMIT;
			ST_EMIT: if (st.out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.in_ready = 1'b1;
			ST_PCHK: cmd.tap_clr  = 1'b1;
			ST_PRD:  cmd.prd_step = 1'b1;
			ST_PMUL: cmd.pmul     = 1'b1;
			ST_PWR:  cmd.pwr      = 1'b1;
			ST_OCHK: cmd.tap_clr  = 1'b1;
			ST_SRD:  cmd.srd_step = 1'b1;
			ST_RND:  cmd.rnd      = 1'b1;
			ST_SQM:  cmd.sqm      = 1'b1;
			ST_SQS:  cmd.sqs      = 1'b1;
			ST_SUM:  cmd.sum      = 1'b1;
			ST_EMIT: cmd.emit     = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule

// ===== hdl/mecr_dp.sv =====
// Datapath: size registers, position counters, line stores, Sobel and window sums,
// root unit and output register. Depends on mecr_pkg, mecr_ram and mecr_isqrt.
module mecr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mecr_pkg::cmd_t                cmd,
	output mecr_pkg::stat_t               st,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [mecr_pkg::DimW-1:0]     cfg_data,
	input  logic                          s_tvalid,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mecr_pkg::OutDataW-1:0] m_tdata,
	output logic                          m_tlast
);
	import mecr_pkg::*;

	function automatic logic [ColW-1:0] refl(input logic signed [12:0] i,
		input logic [DimW-1:0] n);
		logic signed [12:0] v;
		v = (i < 0) ? -i : i;
		if (v >= $signed({2'b00, n})) v = $signed({1'b0, n, 1'b0}) - 13'sd2 - v;
		return v[ColW-1:0];
	endfunction

	logic [DimW-1:0] width_q, height_q, w_eff, h_eff;
	logic [ColW-1:0] in_col_q, prod_col_q, out_col_q;
	logic [RowW-1:0] in_row_q, out_row_q;
	logic [DimW-1:0] prod_row_q;
	logic            frame_in_q;
	logic [TapW-1:0] tap_q;

	logic take, is_pix, cfg_hit, emit_fire, last, restart;
	logic [DimW-1:0] in_col_e, in_row_e, in_col_nx, in_row_nx;
	logic [DimW-1:0] pr1, pc1, or3, oc3, prow_nx, pcol_nx;
	logic [DimW-1:0] ocol_nx;

	// window addressing
	logic [3:0] ptix;
	logic [4:0] stix;
	logic signed [12:0] pr_s, pc_s, sr_s, sc_s;
	logic [ColW-1:0] srow_m, scol_m;
	logic p_issue, p_inr, s_issue;
	logic [PixAw-1:0] pix_raddr;
	logic [ProdAw-1:0] prod_raddr, prod_waddr;
	logic [PixW-1:0] pix_rd;
	logic [ProdW-1:0] prod_rd;

	logic pvld_s1, svld_s1;
	logic signed [2:0] sx_s1, sy_s1;
	logic [5:0] swt_s1;
	logic signed [11:0] gx_q, gy_q, tx, ty;
	logic signed [23:0] mxx, mxy, myy;
	logic [XxW-1:0] xx_q, yy_q;
	logic [XyW-1:0] xy_q;
	logic signed [31:0] sa_q, sb_q, sc_q, ta, tb, tc, sa_r, sb_r, sc_r;
	logic [XxW-1:0] a_q, c_q;
	logic signed [XyW-1:0] b_q, d;
	logic signed [SqW-1:0] dsq, bsq;
	logic [SqW-1:0] dd_q, bb_q, q;
	logic [RootW-1:0] root;
	logic root_done;
	logic [XxW+1:0] acsum;
	logic signed [XxW+2:0] diff;
	logic [RespW-1:0] resp_q;

	logic mv_q, last_q;
	logic [RespW-1:0] oresp_q;
	logic [ColW-1:0] ocol_q;
	logic [RowW-1:0] orow_q;

	assign w_eff = (width_q < DimW'(5)) ? DimW'(5) :
		(width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q;
	assign h_eff = (height_q < DimW'(5)) ? DimW'(5) :
		(height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;

	assign take      = s_tvalid && cmd.in_ready;
	assign is_pix    = take && (s_tuser == REQ_PIXEL) && !frame_in_q;
	assign cfg_hit   = cfg_we && (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT);
	assign emit_fire = cmd.emit && st.out_free;
	assign last      = (DimW'(out_row_q) == h_eff - DimW'(1)) &&
		(DimW'(out_col_q) == w_eff - DimW'(1));
	assign restart   = cfg_hit || (emit_fire && last);

	assign in_col_e  = DimW'(in_col_q);
	assign in_row_e  = DimW'(in_row_q);
	assign in_col_nx = in_col_e + DimW'(1);
	assign in_row_nx = in_row_e + DimW'(1);
	assign prow_nx   = prod_row_q + DimW'(1);
	assign pcol_nx   = DimW'(prod_col_q) + DimW'(1);
	assign ocol_nx   = DimW'(out_col_q) + DimW'(1);
	assign pr1 = (prow_nx >= h_eff) ? h_eff - DimW'(1) : prow_nx;
	assign pc1 = (pcol_nx >= w_eff) ? w_eff - DimW'(1) : pcol_nx;
	assign or3 = (DimW'(out_row_q) + DimW'(3) >= h_eff) ? h_eff - DimW'(1)
		: DimW'(out_row_q) + DimW'(3);
	assign oc3 = (DimW'(out_col_q) + DimW'(3) >= w_eff) ? w_eff - DimW'(1)
		: DimW'(out_col_q) + DimW'(3);

	// a position counts as received when it lies before the input counters in raster order
	assign st.prod_go = (prod_row_q < h_eff) && (frame_in_q || pr1 < in_row_e ||
		(pr1 == in_row_e && pc1 < in_col_e));
	assign st.out_go  = frame_in_q || or3 < in_row_e || (or3 == in_row_e && oc3 < in_col_e);
	assign st.prd_done  = (tap_q == TapW'(ProdTaps));
	assign st.srd_done  = (tap_q == TapW'(ScoreTaps));
	assign st.root_done = root_done;
	assign st.out_free  = !mv_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_addr == REG_WIDTH) width_q <= cfg_data;
			if (cfg_addr == REG_HEIGHT) height_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			prod_col_q <= '0;
			prod_row_q <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			frame_in_q <= 1'b0;
		end else if (restart) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			prod_col_q <= '0;
			prod_row_q <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			frame_in_q <= 1'b0;
		end else begin
			if (is_pix) begin
				if (in_col_nx >= w_eff) begin
					in_col_q <= '0;
					if (in_row_nx >= h_eff) begin
						in_row_q   <= '0;
						frame_in_q <= 1'b1;
					end else begin
						in_row_q <= in_row_nx[RowW-1:0];
					end
				end else begin
					in_col_q <= in_col_nx[ColW-1:0];
				end
			end
			if (cmd.pwr) begin
				if (pcol_nx >= w_eff) begin
					prod_col_q <= '0;
					prod_row_q <= prow_nx;
				end else begin
					prod_col_q <= pcol_nx[ColW-1:0];
				end
			end
			if (emit_fire) begin
				if (ocol_nx >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RowW'(1);
				end else begin
					out_col_q <= ocol_nx[ColW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tap_q <= '0;
		else if (cmd.tap_clr) tap_q <= '0;
		else if (cmd.prd_step || cmd.srd_step) tap_q <= tap_q + TapW'(1);
	end

	// Sobel window reads
	assign ptix    = (tap_q < TapW'(ProdTaps)) ? tap_q[3:0] : 4'(ProdTaps - 1);
	assign pr_s    = $signed({2'b00, prod_row_q}) + $signed({11'b0, TAP_DI[ptix]}) - 13'sd1;
	assign pc_s    = $signed({3'b000, prod_col_q}) + $signed({11'b0, TAP_DJ[ptix]}) - 13'sd1;
	assign p_issue = cmd.prd_step && (tap_q < TapW'(ProdTaps));
	assign p_inr   = (pr_s >= 0) && (pr_s < $signed({2'b00, h_eff})) &&
		(pc_s >= 0) && (pc_s < $signed({2'b00, w_eff}));
	assign pix_raddr = {pr_s[PixLb-1:0], pc_s[ColW-1:0]};

	// score window reads with mirrored borders
	assign stix    = (tap_q < TapW'(ScoreTaps)) ? tap_q : 5'(ScoreTaps - 1);
	assign sr_s    = $signed({3'b000, out_row_q}) + $signed({10'b0, SC_DY[stix]}) - 13'sd2;
	assign sc_s    = $signed({3'b000, out_col_q}) + $signed({10'b0, SC_DX[stix]}) - 13'sd2;
	assign s_issue = cmd.srd_step && (tap_q < TapW'(ScoreTaps));
	assign srow_m  = refl(sr_s, h_eff);
	assign scol_m  = refl(sc_s, w_eff);
	assign prod_raddr = {srow_m[ProdLb-1:0], scol_m};
	assign prod_waddr = {prod_row_q[ProdLb-1:0], prod_col_q};

	mecr_ram #(.Width(PixW), .Depth(PixDepth)) u_pix_ram (
		.clk   (clk),
		.we    (is_pix),
		.waddr ({in_row_q[PixLb-1:0], in_col_q}),
		.wdata (s_tdata),
		.re    (p_issue),
		.raddr (pix_raddr),
		.rdata (pix_rd)
	);

	mecr_ram #(.Width(ProdW), .Depth(ProdDepth)) u_prod_ram (
		.clk   (clk),
		.we    (cmd.pwr),
		.waddr (prod_waddr),
		.wdata ({yy_q, xy_q, xx_q}),
		.re    (s_issue),
		.raddr (prod_raddr),
		.rdata (prod_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_s1 <= 1'b0;
			svld_s1 <= 1'b0;
		end else begin
			pvld_s1 <= p_issue && p_inr;
			svld_s1 <= s_issue;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1  <= SOB_X[ptix];
		sy_s1  <= SOB_Y[ptix];
		swt_s1 <= SC_WT[stix];
	end

	assign tx = $signed(sx_s1) * $signed({4'b0, pix_rd});
	assign ty = $signed(sy_s1) * $signed({4'b0, pix_rd});
	assign ta = $signed({26'b0, swt_s1}) * $signed({11'b0, prod_rd[XxW-1:0]});
	assign tb = $signed({26'b0, swt_s1}) * $signed(prod_rd[XxW+XyW-1:XxW]);
	assign tc = $signed({26'b0, swt_s1}) * $signed({11'b0, prod_rd[ProdW-1:XxW+XyW]});

	assign mxx = gx_q * gx_q;
	assign mxy = gx_q * gy_q;
	assign myy = gy_q * gy_q;

	assign sa_r = sa_q + 32'sd128;
	assign sb_r = sb_q + 32'sd128;
	assign sc_r = sc_q + 32'sd128;

	assign d   = $signed({1'b0, a_q}) - $signed({1'b0, c_q});
	assign dsq = d * d;
	assign bsq = b_q * b_q;
	assign q   = dd_q + (bb_q << 2);

	assign acsum = {2'b00, a_q} + {2'b00, c_q};
	assign diff  = $signed({1'b0, acsum}) - $signed({2'b00, root});

	always_ff @(posedge clk) begin
		if (cmd.tap_clr) begin
			gx_q <= '0;
			gy_q <= '0;
			sa_q <= '0;
			sb_q <= '0;
			sc_q <= '0;
		end else begin
			if (pvld_s1) begin
				gx_q <= gx_q + tx;
				gy_q <= gy_q + ty;
			end
			if (svld_s1) begin
				sa_q <= sa_q + ta;
				sb_q <= sb_q + tb;
				sc_q <= sc_q + tc;
			end
		end
		if (cmd.pmul) begin
			xx_q <= mxx[XxW-1:0];
			xy_q <= mxy[XyW-1:0];
			yy_q <= myy[XxW-1:0];
		end
		// round to nearest on the divide by 256
		if (cmd.rnd) begin
			a_q <= sa_r[XxW+7:8];
			b_q <= sb_r[XyW+7:8];
			c_q <= sc_r[XxW+7:8];
		end
		if (cmd.sqm) begin
			dd_q <= dsq;
			bb_q <= bsq;
		end
		if (cmd.sum) resp_q <= diff[XxW+2] ? '0 : diff[RespW-1:0];
	end

	mecr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqs),
		.value  (q),
		.done   (root_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mv_q <= 1'b0;
		else if (emit_fire) mv_q <= 1'b1;
		else if (m_tready) mv_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			oresp_q <= resp_q;
			ocol_q  <= out_col_q;
			orow_q  <= out_row_q;
			last_q  <= last;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {7'b0, orow_q, ocol_q, oresp_q};
	assign m_tlast  = last_q;

	a_in_col: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_e < w_eff) else $error("input column beyond frame width");
	a_out_row: assert property (@(posedge clk) disable iff (!arst_n)
		DimW'(out_row_q) < h_eff) else $error("output row beyond frame height");
	a_prod_row: assert property (@(posedge clk) disable iff (!arst_n)
		prod_row_q <= h_eff) else $error("product row ran past the frame");
	a_frame_in: assert property (@(posedge clk) disable iff (!arst_n)
		frame_in_q |-> (in_col_q == '0 && in_row_q == '0))
		else $error("input counters moved after the frame was complete");
endmodule

// ===== bench/mecr_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the min-eigenvalue corner scorer: predicts each score from the accepted
// requests and register writes and compares it with the outgoing stream. Needs mecr_pkg.
module mecr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [mecr_pkg::OutDataW-1:0] m_tdata,
	input  logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [mecr_pkg::DimW-1:0]     cfg_data,
	output int                            errors,
	output int                            pending
);
	import mecr_pkg::*;

	typedef struct {
		logic [RespW-1:0] response;
		logic [ColW-1:0]  col;
		logic [RowW-1:0]  row;
		logic             last;
	} score_t;

	localparam longint BINOM [5] = '{1, 4, 6, 4, 1};

	score_t scores_due [$];
	logic [DimW-1:0] width_reg = WIDTH_RST;
	logic [DimW-1:0] height_reg = HEIGHT_RST;
	logic [7:0] pix_line [PixLines][MaxWidth];
	longint gxx [ProdLines][MaxWidth];
	longint gxy [ProdLines][MaxWidth];
	longint gyy [ProdLines][MaxWidth];
	int in_col, in_row, out_col, out_row, prd_col, prd_row;
	bit frame_done;

	assign pending = scores_due.size();
	initial errors = 0;

	function automatic int clamp_dim(int v, int hi);
		return v < 5 ? 5 : (v > hi ? hi : v);
	endfunction

	function automatic int imin(int a, int b);
		return a < b ? a : b;
	endfunction

	function automatic int mirror(int i, int n);
		if (i < 0) i = -i;
		if (i >= n) i = 2 * n - 2 - i;
		return i;
	endfunction

	function automatic int pix(int r, int c, int w, int h);
		if (r < 0 || c < 0 || r >= h || c >= w) return 0;
		return pix_line[r % PixLines][c];
	endfunction

	function automatic void restart();
		in_col = 0; in_row = 0; out_col = 0; out_row = 0;
		prd_col = 0; prd_row = 0; frame_done = 0;
	endfunction

	function automatic void make_gradient(int r, int c, int w, int h);
		int gx, gy;
		gx = pix(r-1, c+1, w, h) - pix(r-1, c-1, w, h)
			+ 2 * (pix(r, c+1, w, h) - pix(r, c-1, w, h))
			+ pix(r+1, c+1, w, h) - pix(r+1, c-1, w, h);
		gy = pix(r+1, c-1, w, h) - pix(r-1, c-1, w, h)
			+ 2 * (pix(r+1, c, w, h) - pix(r-1, c, w, h))
			+ pix(r+1, c+1, w, h) - pix(r-1, c+1, w, h);
		gxx[r % ProdLines][c] = gx * gx;
		gxy[r % ProdLines][c] = gx * gy;
		gyy[r % ProdLines][c] = gy * gy;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [RespW-1:0] corner_score(int r, int c, int w, int h);
		longint sa, sb, sc, a, b, cc, d, s, k;
		longint unsigned q;
		int rr, ci;
		sa = 0; sb = 0; sc = 0;
		for (int dy = -2; dy <= 2; dy++) begin
			rr = mirror(r + dy, h) % ProdLines;
			for (int dx = -2; dx <= 2; dx++) begin
				ci = mirror(c + dx, w);
				k = BINOM[dy+2] * BINOM[dx+2];
				sa += k * gxx[rr][ci];
				sb += k * gxy[rr][ci];
				sc += k * gyy[rr][ci];
			end
		end
		// round to nearest, ties upward
		a = (sa + 128) >>> 8;
		b = (sb + 128) >>> 8;
		cc = (sc + 128) >>> 8;
		d = a - cc;
		q = longint'(d * d) + 4 * longint'(b * b);
		s = a + cc - longint'(int_sqrt(q));
		if (s < 0) s = 0;
		return s[RespW-1:0];
	endfunction

	function automatic void take_request(logic kind, logic [7:0] value);
		int w, h, got, need;
		score_t sc;
		w = clamp_dim(width_reg, MaxWidth);
		h = clamp_dim(height_reg, MaxHeight);
		// pixels arriving while the frame drains are dropped
		if (kind == REQ_PIXEL && !frame_done) begin
			pix_line[in_row % PixLines][in_col] = value;
			if (++in_col >= w) begin
				in_col = 0;
				if (++in_row >= h) begin
					in_row = 0;
					frame_done = 1;
				end
			end
		end
		got = frame_done ? w * h : in_row * w + in_col;
		while (prd_row < h && imin(prd_row + 1, h - 1) * w + imin(prd_col + 1, w - 1) < got) begin
			make_gradient(prd_row, prd_col, w, h);
			if (++prd_col >= w) begin
				prd_col = 0;
				prd_row++;
			end
		end
		need = imin(out_row + 3, h - 1) * w + imin(out_col + 3, w - 1);
		if (need >= got) return;
		sc.response = corner_score(out_row, out_col, w, h);
		sc.col = out_col[ColW-1:0];
		sc.row = out_row[RowW-1:0];
		sc.last = (out_row == h - 1) && (out_col == w - 1);
		scores_due.insert(scores_due.size(), sc);
		if (sc.last) begin
			restart();
		end else if (++out_col >= w) begin
			out_col = 0;
			out_row++;
		end
	endfunction

	initial restart();

	always @(posedge clk) begin
		score_t e;
		if (arst_n) begin
			// compare first: a score leaving now belongs to an earlier request
			if (m_tvalid && m_tready) begin
				if (scores_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected score, expected none, got %h", $time, m_tdata);
				end else begin
					e = scores_due.pop_front();
					if (m_tdata[20:0] !== e.response) begin
						errors++;
						$display("%0t: response expected %0d got %0d", $time, e.response,
							m_tdata[20:0]);
					end
					if (m_tdata[30:21] !== e.col) begin
						errors++;
						$display("%0t: col expected %0d got %0d", $time, e.col, m_tdata[30:21]);
					end
					if (m_tdata[40:31] !== e.row) begin
						errors++;
						$display("%0t: row expected %0d got %0d", $time, e.row, m_tdata[40:31]);
					end
					if (m_tlast !== e.last) begin
						errors++;
						$display("%0t: last expected %0d got %0d", $time, e.last, m_tlast);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_addr == REG_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
				restart();
			end
			if (s_tvalid && s_tready) take_request(s_tuser, s_tdata);
		end
	end
endmodule

// ===== bench/tb_min_eigen_corner_response.sv =====
`timescale 1ns / 100ps
// Top of the corner scorer bench: drives frames, flush ticks and size writes at varying
// idle rates. Needs mecr_pkg, min_eigen_corner_response and mecr_checker.
module tb_min_eigen_corner_response;
	import mecr_pkg::*;

	localparam int WatchLimit = 60000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tuser = REQ_PIXEL;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OutDataW-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 0;
	logic cfg_addr = REG_WIDTH;
	logic [DimW-1:0] cfg_data = '0;
	int errors, pending;
	int gap_pct = 0, stall_pct = 0;
	int cur_w = 640;
	int sent = 0;
	int quiet = 0;

	min_eigen_corner_response i_dut (.*);

	mecr_checker i_chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WatchLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send(logic kind, logic [7:0] value);
		if ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	// hold off until the block is idle, then write one size register
	task automatic write_size(logic idx, logic [DimW-1:0] value);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (13 * (cur_w + 2) + 80) @(posedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_WIDTH) cur_w = value < 5 ? 5 : (value > MaxWidth ? MaxWidth : value);
	endtask

	function automatic logic [7:0] pick_pixel(int style, int r, int c);
		case (style)
			0: return 8'($urandom_range(255));
			1: return ((r + c) % 2) ? 8'd255 : 8'd0;
			2: return (c > r) ? 8'd255 : 8'd0;
			default: return $urandom_range(1) ? 8'd255 : 8'd0;
		endcase
	endfunction

	// one frame: pixels in raster order, optional stray flushes, then a drain unless cut short
	task automatic run_frame(int w, int h, int style, bit cut_short);
		int n;
		n = cut_short ? $urandom_range((w * h - 1 < 40) ? w * h - 1 : 40, 1) : w * h;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 4) send(REQ_FLUSH, 8'($urandom_range(255)));
			send(REQ_PIXEL, pick_pixel(style, i / w, i % w));
		end
		if (!cut_short)
			for (int i = 0; i < 4 * w + 8; i++)
				// a pixel during the drain is dropped by the block until the frame's last score goes out
				send($urandom_range(99) < 15 ? REQ_PIXEL : REQ_FLUSH,
					8'($urandom_range(255)));
	endtask

	initial begin
		int w, h, frame;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(REQ_FLUSH, 8'd0);
		write_size(REG_WIDTH, 11'd5);
		write_size(REG_HEIGHT, 11'd5);
		send(REQ_FLUSH, 8'hFF);
		run_frame(5, 5, 1, 0);
		// extreme and out-of-range sizes, the largest fed only partly
		write_size(REG_WIDTH, 11'd2047);
		write_size(REG_HEIGHT, 11'd1024);
		run_frame(1024, 1024, 0, 1);
		write_size(REG_WIDTH, 11'd1024);
		write_size(REG_HEIGHT, 11'd2047);
		for (int i = 0; i < 12; i++) send(REQ_PIXEL, pick_pixel(0, 0, i));
		write_size(REG_WIDTH, 11'd0);
		write_size(REG_HEIGHT, 11'd3);
		run_frame(5, 5, 2, 0);
		frame = 0;
		while (sent < 740) begin
			case (frame % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 48; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 48; end
				default: begin gap_pct = 34; stall_pct = 34; end
			endcase
			w = $urandom_range(99) < 10 ? $urandom_range(4) : $urandom_range(12, 5);
			h = $urandom_range(99) < 10 ? $urandom_range(4) : $urandom_range(9, 5);
			write_size(REG_WIDTH, DimW'(w));
			write_size(REG_HEIGHT, DimW'(h));
			run_frame(w < 5 ? 5 : w, h < 5 ? 5 : h, $urandom_range(3),
				$urandom_range(99) < 10);
			frame++;
		end
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (13 * (cur_w + 2) + 200) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

// ===== min_eigen_corner_response.f =====
hdl/mecr_pkg.sv
hdl/mecr_ram.sv
hdl/mecr_isqrt.sv
hdl/mecr_ctrl.sv
hdl/mecr_dp.sv
hdl/min_eigen_corner_response.sv
bench/mecr_checker.sv
bench/tb_min_eigen_corner_response.sv
